@@ design/tsmd_pkg.sv @@
// tsmd_pkg: shared constants, result type and byte mask helper for the
// two-way sorted merge with duplicate removal
// no dependencies
package tsmd_pkg;

    localparam int KEY_BYTES_DEF   = 8;
    localparam int VALUE_BYTES_DEF = 8;
    localparam int RES_DEPTH       = 4;

    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_END    = 1'b1;
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;
    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        from_side;
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [63:0] value;
        logic [3:0]  value_len;
        logic        right_dropped;
    } res_t;

    // ones over the first n bytes of a left-aligned word
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [6:0] sh;
        sh = {n, 3'b000};
        return ~({64{1'b1}} >> sh);
    endfunction

endpackage

@@ design/two_way_sorted_merge_dedup_top.sv @@
// two_way_sorted_merge_dedup_top: merges a left and a right sorted stream,
// dropping right entries equal to the winning left key
// depends on tsmd_pkg
//
//  channel  direction  fields
//  s_       in         req_type side key_bytes key_len value_bytes value_len
//  m_       out        kind from_side out_key out_key_len out_value
//                      out_value_len right_dropped
//
// one request per cycle: a request is registered, then the head update and
// key compare run on the registered request and write up to two results into a
// four-entry result queue. s_ready drops only while the queue lacks room for
// two results, so a request can issue every cycle while m_ready keeps up.
// synchronous active-low reset empties both heads, the queue and the end flags.
module two_way_sorted_merge_dedup_top
    import tsmd_pkg::*;
#(
    parameter int KEY_BYTES   = KEY_BYTES_DEF,
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic        s_side,
    input  logic [63:0] s_key_bytes,
    input  logic [3:0]  s_key_len,
    input  logic [63:0] s_value_bytes,
    input  logic [3:0]  s_value_len,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic        m_from_side,
    output logic [63:0] m_out_key,
    output logic [3:0]  m_out_key_len,
    output logic [63:0] m_out_value,
    output logic [3:0]  m_out_value_len,
    output logic        m_right_dropped
);

    localparam logic [3:0] KEY_CAP   = 4'(KEY_BYTES);
    localparam logic [3:0] VALUE_CAP = 4'(VALUE_BYTES);
    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(RES_DEPTH - 2);

    // input register
    logic        in_vld_reg;
    logic        in_req_reg;
    logic        in_side_reg;
    logic [63:0] in_key_reg;
    logic [3:0]  in_klen_reg;
    logic [63:0] in_val_reg;
    logic [3:0]  in_vlen_reg;

    // heads and merge state
    logic [63:0] head_key_reg  [2];
    logic [63:0] head_val_reg  [2];
    logic [3:0]  head_klen_reg [2];
    logic [3:0]  head_vlen_reg [2];
    logic [1:0]  held_reg, held_next;
    logic [63:0] last_key_reg, last_key_next;
    logic [3:0]  last_len_reg, last_len_next;
    logic        last_valid_reg, last_valid_next;
    logic [1:0]  ended_reg, ended_next;

    // result queue
    res_t             res_mem_reg [RES_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic        can_proc;
    logic        proc;
    logic        pop;
    logic        s_fire;

    logic        end_now;
    logic        write_head;
    logic [3:0]  new_klen;
    logic [3:0]  new_vlen;
    logic [63:0] new_key;
    logic [63:0] new_val;
    logic [63:0] k0, k1;
    logic [3:0]  l0, l1;
    logic [1:0]  held_post;
    logic        both_held;
    logic        key_eq;
    logic        left_first;
    logic        pick_vld;
    logic        pick_side;
    logic        dropped;
    res_t        entry_res;
    res_t        end_res;
    logic [1:0]  push_n;

    assign can_proc = (cnt_reg <= ROOM_LIMIT);
    assign proc     = in_vld_reg && can_proc;
    assign s_ready  = !in_vld_reg || can_proc;
    assign s_fire   = s_valid && s_ready;
    assign pop      = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg  <= s_req_type;
            in_side_reg <= s_side;
            in_key_reg  <= s_key_bytes;
            in_klen_reg <= s_key_len;
            in_val_reg  <= s_value_bytes;
            in_vlen_reg <= s_value_len;
        end
    end

    always_comb begin
        new_klen = (in_klen_reg > KEY_CAP) ? KEY_CAP : in_klen_reg;
        new_vlen = (in_vlen_reg > VALUE_CAP) ? VALUE_CAP : in_vlen_reg;
        new_key  = in_key_reg & byte_mask(new_klen);
        new_val  = in_val_reg & byte_mask(new_vlen);

        ended_next = ended_reg;
        end_now    = 1'b0;
        write_head = 1'b0;
        if (in_req_reg == REQ_END) begin
            ended_next[in_side_reg] = 1'b1;
            end_now = (ended_reg != 2'b11) && (ended_next == 2'b11);
        end else if (!ended_reg[in_side_reg] && !held_reg[in_side_reg]) begin
            write_head = !((in_side_reg == SIDE_RIGHT) && last_valid_reg &&
                           (new_key == last_key_reg) && (new_klen == last_len_reg));
        end

        held_post = held_reg;
        if (write_head) begin
            held_post[in_side_reg] = 1'b1;
        end
        k0 = (write_head && in_side_reg == SIDE_LEFT)  ? new_key  : head_key_reg[0];
        l0 = (write_head && in_side_reg == SIDE_LEFT)  ? new_klen : head_klen_reg[0];
        k1 = (write_head && in_side_reg == SIDE_RIGHT) ? new_key  : head_key_reg[1];
        l1 = (write_head && in_side_reg == SIDE_RIGHT) ? new_klen : head_klen_reg[1];

        both_held  = held_post[0] && held_post[1];
        key_eq     = (k0 == k1) && (l0 == l1);
        left_first = (k0 < k1) || ((k0 == k1) && (l0 <= l1));

        pick_vld  = 1'b0;
        pick_side = SIDE_LEFT;
        dropped   = 1'b0;
        if (both_held) begin
            pick_vld  = 1'b1;
            pick_side = left_first ? SIDE_LEFT : SIDE_RIGHT;
            dropped   = key_eq;
        end else if (held_post[0] && ended_next[1]) begin
            pick_vld  = 1'b1;
            pick_side = SIDE_LEFT;
        end else if (held_post[1] && ended_next[0]) begin
            pick_vld  = 1'b1;
            pick_side = SIDE_RIGHT;
        end

        held_next       = held_post;
        last_key_next   = last_key_reg;
        last_len_next   = last_len_reg;
        last_valid_next = last_valid_reg;
        if (pick_vld) begin
            held_next[pick_side] = 1'b0;
            if (dropped) begin
                held_next[1] = 1'b0;
            end
            if (pick_side == SIDE_LEFT) begin
                last_key_next   = k0;
                last_len_next   = l0;
                last_valid_next = 1'b1;
            end else begin
                last_valid_next = 1'b0;
            end
        end

        entry_res.kind          = KIND_ENTRY;
        entry_res.from_side     = pick_side;
        entry_res.key           = (pick_side == SIDE_LEFT) ? k0 : k1;
        entry_res.key_len       = (pick_side == SIDE_LEFT) ? l0 : l1;
        entry_res.right_dropped = dropped;
        if (write_head && in_side_reg == pick_side) begin
            entry_res.value     = new_val;
            entry_res.value_len = new_vlen;
        end else begin
            entry_res.value     = head_val_reg[pick_side];
            entry_res.value_len = head_vlen_reg[pick_side];
        end

        end_res      = '0;
        end_res.kind = KIND_END;

        push_n = proc ? ({1'b0, pick_vld} + {1'b0, end_now}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg       <= 2'b00;
            ended_reg      <= 2'b00;
            last_valid_reg <= 1'b0;
            last_key_reg   <= '0;
            last_len_reg   <= '0;
        end else if (proc) begin
            held_reg       <= held_next;
            ended_reg      <= ended_next;
            last_valid_reg <= last_valid_next;
            last_key_reg   <= last_key_next;
            last_len_reg   <= last_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && write_head) begin
            head_key_reg[in_side_reg]  <= new_key;
            head_klen_reg[in_side_reg] <= new_klen;
            head_val_reg[in_side_reg]  <= new_val;
            head_vlen_reg[in_side_reg] <= new_vlen;
        end
    end

    // result queue: entry first, end result after it
    always_ff @(posedge aclk) begin
        if (proc) begin
            if (pick_vld) begin
                res_mem_reg[wr_ptr_reg] <= entry_res;
                if (end_now) begin
                    res_mem_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= end_res;
                end
            end else if (end_now) begin
                res_mem_reg[wr_ptr_reg] <= end_res;
            end
        end
    end

    always_comb begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + push_n);
        rd_ptr_next = PTR_W'(rd_ptr_reg + pop);
        cnt_next    = CNT_W'(cnt_reg + push_n - pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign m_valid         = (cnt_reg != '0);
    assign m_kind          = res_mem_reg[rd_ptr_reg].kind;
    assign m_from_side     = res_mem_reg[rd_ptr_reg].from_side;
    assign m_out_key       = res_mem_reg[rd_ptr_reg].key;
    assign m_out_key_len   = res_mem_reg[rd_ptr_reg].key_len;
    assign m_out_value     = res_mem_reg[rd_ptr_reg].value;
    assign m_out_value_len = res_mem_reg[rd_ptr_reg].value_len;
    assign m_right_dropped = res_mem_reg[rd_ptr_reg].right_dropped;

endmodule

@@ design/tsmd_checker.sv @@
// tsmd_checker: port-level assertions for the sorted merge, with the bind
// that attaches it to two_way_sorted_merge_dedup_top
// depends on tsmd_pkg
module tsmd_checker
    import tsmd_pkg::*;
#(
    parameter int KEY_BYTES   = KEY_BYTES_DEF,
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic        m_from_side,
    input logic [63:0] m_out_key,
    input logic [3:0]  m_out_key_len,
    input logic [63:0] m_out_value,
    input logic [3:0]  m_out_value_len,
    input logic        m_right_dropped
);

    localparam logic [3:0] KEY_CAP   = 4'(KEY_BYTES);
    localparam logic [3:0] VALUE_CAP = 4'(VALUE_BYTES);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_out_key)
            && $stable(m_out_value) && $stable(m_from_side))
        else $error("stalled result changed");

    // end result carries nothing else
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END |-> m_out_key == '0 && m_out_value == '0
            && m_out_key_len == '0 && m_out_value_len == '0
            && m_from_side == 1'b0 && m_right_dropped == 1'b0)
        else $error("end result with payload");

    // lengths stay capped
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ENTRY |->
            m_out_key_len <= KEY_CAP && m_out_value_len <= VALUE_CAP)
        else $error("length above cap");

    // bytes past the length are zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ENTRY |->
            (m_out_key & ~byte_mask(m_out_key_len)) == '0 &&
            (m_out_value & ~byte_mask(m_out_value_len)) == '0)
        else $error("nonzero padding");

    // a dropped right entry only goes with a left emission
    a_drop_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_right_dropped |-> m_from_side == SIDE_LEFT && m_kind == KIND_ENTRY)
        else $error("drop flag on right emission");

endmodule

bind two_way_sorted_merge_dedup_top tsmd_checker #(
    .KEY_BYTES(KEY_BYTES),
    .VALUE_BYTES(VALUE_BYTES)
) u_tsmd_checker (.*);
